>>> rtl/core/srpv_pkg.sv
// Shared types, constants and character codes of the sensor record parser.
package srpv_pkg;

  localparam int NUM_FIELDS = 6;
  localparam int ACC_W      = 15;
  localparam int WIDE_W     = 19;
  localparam int VALUE_W    = 14;
  localparam int MASK_W     = 7;
  localparam int LINE_W     = 32;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [2:0]               field_idx_t;
  typedef logic [MASK_W-1:0]        mask_t;

  localparam acc_t  VALUE_MAX      = 15'sd9999;
  localparam wide_t WIDE_VALUE_MAX = 19'sd9999;
  localparam acc_t  TEMP_LOW_RST   = -15'sd99;
  localparam acc_t  TEMP_HIGH_RST  = 15'sd99;

  // field positions within a record
  localparam field_idx_t FIELD_YEAR   = 3'd0;
  localparam field_idx_t FIELD_MONTH  = 3'd1;
  localparam field_idx_t FIELD_DAY    = 3'd2;
  localparam field_idx_t FIELD_HOUR   = 3'd3;
  localparam field_idx_t FIELD_MINUTE = 3'd4;
  localparam field_idx_t FIELD_TEMP   = 3'd5;
  localparam field_idx_t FIELD_EXTRA  = 3'd6;

  localparam int EXTRA_BIT = 6;

  localparam logic [2:0] YEAR_DIGITS   = 3'd4;
  localparam logic [2:0] YEAR_CNT_MAX  = 3'd7;

  localparam acc_t MONTH_FEB    = 15'sd2;
  localparam acc_t MONTH_LAST   = 15'sd12;
  localparam acc_t DAYS_LONG    = 15'sd31;
  localparam acc_t DAYS_SHORT   = 15'sd30;
  localparam acc_t DAYS_FEB_LP  = 15'sd29;
  localparam acc_t DAYS_FEB     = 15'sd28;
  localparam acc_t HOUR_MAX     = 15'sd23;
  localparam acc_t MINUTE_MAX   = 15'sd59;

  // character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 2'd1;

  // record state carried between bytes
  typedef struct packed {
    field_idx_t                  field_index;
    logic                        minus_seen;
    acc_t [NUM_FIELDS-1:0]       acc;
    logic [2:0]                  year_cnt;
    mask_t                       flags;
  } rec_t;

  localparam rec_t REC_CLEAR = '0;

endpackage

>>> rtl/core/srpv_digit.sv
// Decimal digit accumulate with signed saturation at +/-9999.
module srpv_digit
  import srpv_pkg::*;
(
  input  acc_t       acc,
  input  logic [3:0] digit,
  input  logic       negate,
  output acc_t       acc_next
);

  wide_t ext;
  wide_t prod;
  wide_t dg;
  wide_t sum;
  wide_t sat;

  always_comb begin
    ext  = WIDE_W'(acc);
    prod = (ext <<< 3) + (ext <<< 1);
    dg   = wide_t'({{(WIDE_W-4){1'b0}}, digit});
    sum  = negate ? (prod - dg) : (prod + dg);
    if (sum > WIDE_VALUE_MAX) begin
      sat = WIDE_VALUE_MAX;
    end else if (sum < -WIDE_VALUE_MAX) begin
      sat = -WIDE_VALUE_MAX;
    end else begin
      sat = sum;
    end
    acc_next = sat[ACC_W-1:0];
  end

endmodule

>>> rtl/core/srpv_check.sv
// End-of-record field checks producing the error mask.
module srpv_check
  import srpv_pkg::*;
(
  input  rec_t  rec,
  input  acc_t  temp_low,
  input  acc_t  temp_high,
  output mask_t mask
);

  acc_t y;
  acc_t mo;
  acc_t d;
  acc_t h;
  acc_t mi;
  acc_t t;
  acc_t dmax;

  always_comb begin
    y  = rec.acc[FIELD_YEAR];
    mo = rec.acc[FIELD_MONTH];
    d  = rec.acc[FIELD_DAY];
    h  = rec.acc[FIELD_HOUR];
    mi = rec.acc[FIELD_MINUTE];
    t  = rec.acc[FIELD_TEMP];

    unique case (mo)
      15'sd1, 15'sd3, 15'sd5, 15'sd7, 15'sd8, 15'sd10, 15'sd12: dmax = DAYS_LONG;
      15'sd4, 15'sd6, 15'sd9, 15'sd11:                          dmax = DAYS_SHORT;
      MONTH_FEB: dmax = (y[1:0] == 2'b00) ? DAYS_FEB_LP : DAYS_FEB;
      default:   dmax = '0;
    endcase

    mask = rec.flags;
    if (rec.year_cnt != YEAR_DIGITS)                    mask[FIELD_YEAR]   = 1'b1;
    if (mo < 15'sd1 || mo > MONTH_LAST)                 mask[FIELD_MONTH]  = 1'b1;
    // no day check when the month itself is bad
    if (dmax != '0 && (d < 15'sd1 || d > dmax))         mask[FIELD_DAY]    = 1'b1;
    if (h < 15'sd0 || h > HOUR_MAX)                     mask[FIELD_HOUR]   = 1'b1;
    if (mi < 15'sd0 || mi > MINUTE_MAX)                 mask[FIELD_MINUTE] = 1'b1;
    if (t < temp_low || t > temp_high)                  mask[FIELD_TEMP]   = 1'b1;
  end

endmodule

>>> rtl/core/sensor_record_parser_validator_unit.sv
// Top level of the sensor record parser and validator.
// Items pass through an input register; a record end loads the result register once that is free.
// Throughput: one item per cycle unless in_stall is high; the single-byte step on the record state sets this.
// in_stall rises only while a finished result waits and the next item ends a record.
// Reset (rst, synchronous, active high) clears record state, the line counter and
// both valid flags, and sets the temperature limits to -99 and 99.
module sensor_record_parser_validator_unit
  import srpv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_byte,
  input  logic                 end_of_input,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 record_valid,
  output logic [VALUE_W-1:0]   year_value,
  output logic [VALUE_W-1:0]   month_value,
  output logic [VALUE_W-1:0]   day_value,
  output logic [VALUE_W-1:0]   hour_value,
  output logic [VALUE_W-1:0]   minute_value,
  output logic signed [ACC_W-1:0] temperature_value,
  output logic [MASK_W-1:0]    field_error_mask,
  output logic [LINE_W-1:0]    line_number,
  output logic                 stream_done,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ACC_W-1:0]     cfg_data
);

  // input register
  logic        ireg_valid;
  logic [7:0]  ireg_byte;
  logic        ireg_eoi;

  // record state and line counter
  rec_t              rec;
  rec_t              rec_next;
  logic [LINE_W-1:0] lines_seen;
  logic [LINE_W-1:0] lines_seen_next;

  acc_t temp_low;
  acc_t temp_high;

  // per-byte decode
  logic [7:0] c;
  logic       is_digit;
  logic       ends;
  logic       out_free;
  logic       proc;
  acc_t       sel_acc;
  acc_t       digit_acc;
  logic       negate;
  mask_t      mask;
  logic [LINE_W-1:0] line_cur;

  assign cfg_ready = 1'b1;

  // space counts as digit zero
  assign c        = (ireg_byte == CHAR_SPACE) ? CHAR_ZERO : ireg_byte;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign ends     = ireg_eoi || (c == CHAR_NL);

  // an item holding a record end may move only when the result register is free
  assign out_free = !out_valid || !out_stall;
  assign proc     = ireg_valid && (!ends || out_free);
  assign in_stall = ireg_valid && !proc;

  assign negate   = (rec.field_index == FIELD_TEMP) && rec.minus_seen;
  assign line_cur = lines_seen + 32'd1;

  // accumulator of the current field; extra field reads as zero, never written
  always_comb begin
    sel_acc = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (rec.field_index == 3'(i)) sel_acc = rec.acc[i];
    end
  end

  srpv_digit u_digit (
    .acc      (sel_acc),
    .digit    (c[3:0]),
    .negate   (negate),
    .acc_next (digit_acc)
  );

  srpv_check u_check (
    .rec       (rec),
    .temp_low  (temp_low),
    .temp_high (temp_high),
    .mask      (mask)
  );

  // next record state for the byte in the input register
  always_comb begin
    rec_next        = rec;
    lines_seen_next = lines_seen;
    if (ends) begin
      rec_next        = REC_CLEAR;
      // end of stream restarts line numbering
      lines_seen_next = ireg_eoi ? '0 : line_cur;
    end else if (c == CHAR_SEMI) begin
      if (rec.field_index >= FIELD_TEMP) begin
        rec_next.flags[EXTRA_BIT] = 1'b1;
        rec_next.field_index      = FIELD_EXTRA;
      end else begin
        rec_next.field_index = rec.field_index + 3'd1;
      end
    end else if (rec.field_index >= FIELD_EXTRA) begin
      // bytes in an extra field are dropped
    end else if (rec.field_index == FIELD_TEMP) begin
      if (c == CHAR_MINUS) begin
        rec_next.minus_seen = 1'b1;
      end else if (is_digit) begin
        rec_next.acc[FIELD_TEMP] = digit_acc;
      end else begin
        rec_next.flags[FIELD_TEMP] = 1'b1;
      end
    end else if (is_digit) begin
      for (int i = 0; i < NUM_FIELDS - 1; i++) begin
        if (rec.field_index == 3'(i)) rec_next.acc[i] = digit_acc;
      end
      if (rec.field_index == FIELD_YEAR && rec.year_cnt < YEAR_CNT_MAX) begin
        rec_next.year_cnt = rec.year_cnt + 3'd1;
      end
    end else begin
      rec_next.flags[rec.field_index] = 1'b1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (!in_stall) begin
      ireg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      ireg_byte <= char_byte;
      ireg_eoi  <= end_of_input;
    end
  end

  // record state, line counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rec        <= REC_CLEAR;
      lines_seen <= '0;
    end else if (proc) begin
      rec        <= rec_next;
      lines_seen <= lines_seen_next;
    end
  end

  // temperature limits
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_low  <= TEMP_LOW_RST;
      temp_high <= TEMP_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_LOW:  temp_low  <= cfg_data;
        CFG_TEMP_HIGH: temp_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (proc && ends) || (out_valid && out_stall);
    end
    if (proc && ends) begin
      record_valid      <= (mask == '0);
      year_value        <= rec.acc[FIELD_YEAR][VALUE_W-1:0];
      month_value       <= rec.acc[FIELD_MONTH][VALUE_W-1:0];
      day_value         <= rec.acc[FIELD_DAY][VALUE_W-1:0];
      hour_value        <= rec.acc[FIELD_HOUR][VALUE_W-1:0];
      minute_value      <= rec.acc[FIELD_MINUTE][VALUE_W-1:0];
      temperature_value <= rec.acc[FIELD_TEMP];
      field_error_mask  <= mask;
      line_number       <= line_cur;
      stream_done       <= ireg_eoi;
    end
  end

endmodule

>>> rtl/core/srpv_checker.sv
// Port-level assertions for the record parser, bound to the top level.
module srpv_checker
  import srpv_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 record_valid,
  input logic [VALUE_W-1:0]   month_value,
  input logic [VALUE_W-1:0]   day_value,
  input logic [VALUE_W-1:0]   hour_value,
  input logic [VALUE_W-1:0]   minute_value,
  input logic [MASK_W-1:0]    field_error_mask,
  input logic [LINE_W-1:0]    line_number,
  input logic                 stream_done
);

  // line number the next result should carry
  logic [LINE_W-1:0] exp_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_line <= 32'd1;
    end else if (out_valid && !out_stall) begin
      exp_line <= stream_done ? 32'd1 : (line_number + 32'd1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_number) && $stable(field_error_mask))
    else $error("result changed while stalled");

  a_valid_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (record_valid == (field_error_mask == '0)))
    else $error("record_valid disagrees with error mask");

  a_line_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_number == exp_line))
    else $error("line number out of sequence");

  a_valid_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_valid |->
      (month_value >= 14'd1) && (month_value <= 14'd12) && (day_value >= 14'd1) &&
      (hour_value <= 14'd23) && (minute_value <= 14'd59))
    else $error("valid record with field out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind sensor_record_parser_validator_unit srpv_checker u_srpv_checker (.*);

>>> tb/tb_sensor_record_parser_validator_unit.sv
// Self-checking testbench for the sensor record parser and validator unit.
`timescale 1ns / 100ps

module tb_sensor_record_parser_validator_unit;
  import srpv_pkg::*;

  // Error mask bits as they appear on field_error_mask
  localparam mask_t M_YEAR   = 7'h01;
  localparam mask_t M_MONTH  = 7'h02;
  localparam mask_t M_DAY    = 7'h04;
  localparam mask_t M_HOUR   = 7'h08;
  localparam mask_t M_MINUTE = 7'h10;
  localparam mask_t M_TEMP   = 7'h20;
  localparam mask_t M_EXTRA  = 7'h40;

  // Register indexes the block has no register behind; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // A string cannot carry NUL, so the probe rows use '@' in its place
  localparam logic [7:0] NUL_MARK = 8'h40;

  localparam int MAX_IDLE       = 16;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 6;     // margin after the last owed result
  localparam int STUCK_LIMIT    = 4000;  // cycles with no handshake at all
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 330;
  localparam int PRESSURE_PHASE = 3;
  localparam int PROBE_ROWS     = 14;

  // One finished record as the block should report it
  typedef struct packed {
    logic                 ok;
    logic [VALUE_W-1:0]   yr, mo, dy, hr, mi;
    logic [ACC_W-1:0]     tmp;
    mask_t                mask;
    logic [LINE_W-1:0]    line;
    logic                 done;
  } parsed_rec_t;

  // Directed probe: the text of one record and, where obvious, its verdict
  typedef struct {
    string             txt;
    logic              ends_stream;
    logic              pin;
    mask_t             mask;
    logic [LINE_W-1:0] line;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst;

  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           char_byte;
  logic                 end_of_input;
  logic                 out_valid;
  logic                 out_stall;
  logic                 record_valid;
  logic [VALUE_W-1:0]   year_value;
  logic [VALUE_W-1:0]   month_value;
  logic [VALUE_W-1:0]   day_value;
  logic [VALUE_W-1:0]   hour_value;
  logic [VALUE_W-1:0]   minute_value;
  logic signed [ACC_W-1:0] temperature_value;
  logic [MASK_W-1:0]    field_error_mask;
  logic [LINE_W-1:0]    line_number;
  logic                 stream_done;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ACC_W-1:0]     cfg_data;

  sensor_record_parser_validator_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .char_byte         (char_byte),
    .end_of_input      (end_of_input),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .record_valid      (record_valid),
    .year_value        (year_value),
    .month_value       (month_value),
    .day_value         (day_value),
    .hour_value        (hour_value),
    .minute_value      (minute_value),
    .temperature_value (temperature_value),
    .field_error_mask  (field_error_mask),
    .line_number       (line_number),
    .stream_done       (stream_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: record state, line counter and temperature limits
  // ---------------------------------------------------------------------------
  int                cur_field;
  logic              minus_on;
  int                acc [NUM_FIELDS];
  int                year_digits;
  mask_t             rec_flags;
  logic [LINE_W-1:0] lines_done;
  int                lim_lo;
  int                lim_hi;

  parsed_rec_t awaited_records [$];   // results owed by the block, oldest first
  logic [7:0]  rec_bytes [$];         // text of the record being built
  logic        rec_ends_stream;

  int   mismatches;
  logic src_quiet;     // sender runs without gaps
  logic sink_quiet;    // receiver takes results without stalling
  logic hold_off_req;  // receiver to hold off for HOLD_CYCLES
  int   stuck_cycles;

  function automatic void clear_record();
    cur_field   = 0;
    minus_on    = 1'b0;
    foreach (acc[i]) acc[i] = 0;
    year_digits = 0;
    rec_flags   = '0;
  endfunction

  // Advance the mirror by one byte; returns 1 when the byte ends a record
  function automatic logic parse_byte(input logic [7:0] raw, input logic eoi,
                                      output parsed_rec_t r);
    logic [7:0] c;
    int         v;
    int         dg;
    int         dmax;
    mask_t      m;
    c = (raw == CHAR_SPACE) ? CHAR_ZERO : raw;
    r = '0;
    if (eoi || c == CHAR_NL) begin
      m = rec_flags;
      if (year_digits != int'(YEAR_DIGITS)) m |= M_YEAR;
      if (acc[FIELD_MONTH] < 1 || acc[FIELD_MONTH] > MONTH_LAST) m |= M_MONTH;
      case (acc[FIELD_MONTH])
        1, 3, 5, 7, 8, 10, 12: dmax = DAYS_LONG;
        4, 6, 9, 11:           dmax = DAYS_SHORT;
        MONTH_FEB:             dmax = (acc[FIELD_YEAR] % 4 == 0) ? DAYS_FEB_LP : DAYS_FEB;
        default:               dmax = 0;   // bad month: day left unchecked
      endcase
      if (dmax != 0 && (acc[FIELD_DAY] < 1 || acc[FIELD_DAY] > dmax)) m |= M_DAY;
      if (acc[FIELD_HOUR] > HOUR_MAX) m |= M_HOUR;
      if (acc[FIELD_MINUTE] > MINUTE_MAX) m |= M_MINUTE;
      if (acc[FIELD_TEMP] < lim_lo || acc[FIELD_TEMP] > lim_hi) m |= M_TEMP;
      r.ok   = (m == '0);
      r.yr   = acc[FIELD_YEAR][VALUE_W-1:0];
      r.mo   = acc[FIELD_MONTH][VALUE_W-1:0];
      r.dy   = acc[FIELD_DAY][VALUE_W-1:0];
      r.hr   = acc[FIELD_HOUR][VALUE_W-1:0];
      r.mi   = acc[FIELD_MINUTE][VALUE_W-1:0];
      r.tmp  = acc[FIELD_TEMP][ACC_W-1:0];
      r.mask = m;
      r.line = lines_done + 1'b1;
      r.done = eoi;
      clear_record();
      lines_done = eoi ? '0 : lines_done + 1'b1;
      return 1'b1;
    end
    if (c == CHAR_SEMI) begin
      if (cur_field >= NUM_FIELDS - 1) begin
        rec_flags |= M_EXTRA;
        cur_field = NUM_FIELDS;
      end else begin
        cur_field++;
      end
      return 1'b0;
    end
    if (cur_field >= NUM_FIELDS) return 1'b0;   // extra field: byte dropped
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      dg = c - CHAR_ZERO;
      if (cur_field == FIELD_TEMP && minus_on) dg = -dg;
      v = acc[cur_field] * 10 + dg;
      if (v > int'(VALUE_MAX)) v = VALUE_MAX;
      if (v < -int'(VALUE_MAX)) v = -int'(VALUE_MAX);
      acc[cur_field] = v;
      if (cur_field == FIELD_YEAR && year_digits < int'(YEAR_CNT_MAX)) year_digits++;
    end else if (cur_field == FIELD_TEMP && c == CHAR_MINUS) begin
      minus_on = 1'b1;
    end else begin
      rec_flags |= mask_t'(1) << cur_field;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Record text generation
  // ---------------------------------------------------------------------------
  function automatic int num_width(input int v);
    int w = 1;
    while (v >= 10) begin
      v /= 10;
      w++;
    end
    return w;
  endfunction

  // ndig decimal digits of v; leading zeros sometimes written as spaces
  function automatic void add_digits(input int v, input int ndig);
    int   p = 1;
    int   d;
    logic lead = 1'b1;
    repeat (ndig - 1) p *= 10;
    for (int k = 0; k < ndig; k++) begin
      d = (v / p) % 10;
      if (d != 0) lead = 1'b0;
      if (lead && k < ndig - 1 && $urandom_range(0, 3) == 0) rec_bytes.push_back(CHAR_SPACE);
      else rec_bytes.push_back(CHAR_ZERO + 8'(d));
      p /= 10;
    end
  endfunction

  function automatic void add_field(input int v);
    add_digits(v, num_width(v) + ($urandom_range(0, 4) == 0));
    rec_bytes.push_back(CHAR_SEMI);
  endfunction

  // Mostly well-formed records with random content, some noise and damage
  function automatic void build_record();
    int r;
    int v;
    rec_bytes.delete();
    rec_ends_stream = ($urandom_range(0, 99) < 4);
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 24)) rec_bytes.push_back(8'($urandom_range(0, 255)));
      if (!rec_ends_stream) rec_bytes.push_back(CHAR_NL);
      return;
    end
    // year: usually four digits, around the leap-year boundary cases
    r = $urandom_range(0, 99);
    if (r < 50) add_digits($urandom_range(1896, 2104), 4);
    else if (r < 85) add_digits($urandom_range(0, 9999), 4);
    else add_digits($urandom_range(0, 999999), $urandom_range(0, 6));
    rec_bytes.push_back(CHAR_SEMI);
    r = $urandom_range(0, 99);
    add_field(r < 25 ? int'(MONTH_FEB) : r < 90 ? $urandom_range(1, 12) : $urandom_range(0, 99));
    r = $urandom_range(0, 99);
    add_field(r < 30 ? $urandom_range(27, 31) : r < 90 ? $urandom_range(1, 31)
                                                       : $urandom_range(0, 99));
    add_field($urandom_range(0, 9) != 0 ? $urandom_range(0, 23) : $urandom_range(0, 99));
    add_field($urandom_range(0, 9) != 0 ? $urandom_range(0, 59) : $urandom_range(0, 99));
    // temperature: mostly near the limits, sometimes huge, sometimes a late minus
    r = $urandom_range(0, 99);
    if (r < 5) begin
      add_digits($urandom_range(1, 99), $urandom_range(1, 2));
      rec_bytes.push_back(CHAR_MINUS);
      add_digits($urandom_range(0, 99), $urandom_range(1, 2));
    end else begin
      v = (r < 70) ? $urandom_range(0, 200) : (r < 90) ? $urandom_range(0, 9999)
                                                       : $urandom_range(10000, 999999);
      if ($urandom_range(0, 1) == 1) rec_bytes.push_back(CHAR_MINUS);
      add_digits(v, num_width(v));
    end
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 2)) begin
        rec_bytes.push_back(CHAR_SEMI);
        add_digits($urandom_range(0, 99), $urandom_range(0, 2));
      end
    end
    if ($urandom_range(0, 99) < 5)
      rec_bytes.insert($urandom_range(0, rec_bytes.size()), 8'($urandom_range(0, 255)));
    if (!rec_ends_stream) rec_bytes.push_back(CHAR_NL);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------
  // Offer one item after a random gap; on acceptance log the record it closes.
  // A pinned verdict overrides the mirror's mask, valid flag and line number.
  task automatic send_byte(input logic [7:0] c, input logic eoi, input logic pin,
                           input mask_t pmask, input logic [LINE_W-1:0] pline);
    int          gap;
    parsed_rec_t r;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_byte    <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    if (parse_byte(c, eoi, r)) begin
      if (pin) begin
        r.mask = pmask;
        r.ok   = (pmask == '0);
        r.line = pline;
      end
      awaited_records.push_back(r);
    end
  endtask

  task automatic send_record();
    foreach (rec_bytes[k]) send_byte(rec_bytes[k], 1'b0, 1'b0, '0, '0);
    if (rec_ends_stream) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0, '0);
  endtask

  // Stop offering, let every owed record come out, then settle for SETTLE_CYCLES
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both limits, optionally also poking the unused indexes
  task automatic program_limits(input int lo, input int hi, input logic spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [ACC_W-1:0]     val;
    logic signed [ACC_W-1:0] sval;
    idx = '{CFG_TEMP_LOW, CFG_SPARE_A, CFG_TEMP_HIGH, CFG_SPARE_B};
    for (int k = 0; k < 4; k++) begin
      if (spare || idx[k] == CFG_TEMP_LOW || idx[k] == CFG_TEMP_HIGH) begin
        val = (idx[k] == CFG_TEMP_LOW) ? lo[ACC_W-1:0] :
              (idx[k] == CFG_TEMP_HIGH) ? hi[ACC_W-1:0] : ACC_W'($urandom);
        cfg_valid <= 1'b1;
        cfg_index <= idx[k];
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sval = val;
        if (idx[k] == CFG_TEMP_LOW) lim_lo = sval;
        else if (idx[k] == CFG_TEMP_HIGH) lim_hi = sval;
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got, input logic [LINE_W-1:0] line);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("record on line %0d: %s expected %0h, got %0h", line, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    parsed_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record, line %0d", line_number);
      end else begin
        want = awaited_records.pop_front();
        compare_field("record_valid", want.ok, record_valid, want.line);
        compare_field("year", want.yr, year_value, want.line);
        compare_field("month", want.mo, month_value, want.line);
        compare_field("day", want.dy, day_value, want.line);
        compare_field("hour", want.hr, hour_value, want.line);
        compare_field("minute", want.mi, minute_value, want.line);
        compare_field("temperature", want.tmp, $unsigned(temperature_value), want.line);
        compare_field("error mask", want.mask, field_error_mask, want.line);
        compare_field("line number", want.line, line_number, want.line);
        compare_field("stream_done", want.done, stream_done, want.line);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_sensor_record_parser_validator_unit failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall per result, quiet stretches, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // block fills while held: output register full, then the input stalls
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = sink_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Directed probes. Terminating newlines are part of the text; rows marked
  // as ending the stream are followed by an end-of-input item instead.
  // ---------------------------------------------------------------------------
  probe_row_t probes [PROBE_ROWS] = '{
    // end of input straight after reset: empty line, year and month bad
    '{"", 1'b1, 1'b1, M_YEAR | M_MONTH, 1},
    // leap February 29th, hour and minute at top, temperature at lower limit
    '{"2024;02;29;23;59;-99\n", 1'b0, 1'b1, '0, 1},
    // February 29th outside a leap year
    '{"2023;02;29;00;00;99\n", 1'b0, 1'b1, M_DAY, 2},
    // all over range: five-digit year saturates, bad month skips the day check
    '{"99999;13;31;24;60;100\n", 1'b0, 1'b1,
      M_YEAR | M_MONTH | M_HOUR | M_MINUTE | M_TEMP, 3},
    // thirty-day month with day 31, temperature just below the limit
    '{"2024;4;31;1;2;-100\n", 1'b0, 1'b1, M_DAY | M_TEMP, 4},
    // spaces as zeros, minus after digits in the temperature
    '{"20 4;1 ;  ;0;0;12-3\n", 1'b0, 1'b0, '0, 0},
    // stray carriage return, NUL and 0xFF in three fields
    '{"2024\015;1;@1;0;0;\377\n", 1'b0, 1'b1, M_YEAR | M_DAY | M_TEMP, 6},
    // extra fields with junk inside them
    '{"2024;1;1;0;0;0;5x;\n", 1'b0, 1'b0, '0, 0},
    // minus outside the temperature field is a stray byte
    '{"-2024;1;1;0;0;0\n", 1'b0, 1'b1, M_YEAR, 8},
    // temperature saturates at the negative extreme
    '{"2000;12;31;0;0;-99999\n", 1'b0, 1'b1, M_TEMP, 9},
    // bare newline
    '{"\n", 1'b0, 1'b1, M_YEAR | M_MONTH, 10},
    // record closed by end of input, century year counts as leap
    '{"1900;2;29;0;0;0", 1'b1, 1'b0, '0, 0},
    // new stream restarts at line one
    '{"2001;11;30;12;30;-5\n", 1'b0, 1'b0, '0, 0},
    // end of input right after a newline gives an empty record
    '{"", 1'b1, 1'b1, M_YEAR | M_MONTH, 2}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] b;
    logic       last;
    int         lo;
    int         hi;
    int         sent;
    rst          = 1'b1;
    in_valid     = 1'b0;
    char_byte    = '0;
    end_of_input = 1'b0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_TEMP_LOW;
    cfg_data     = '0;
    mismatches   = 0;
    stuck_cycles = 0;
    src_quiet    = 1'b0;
    sink_quiet   = 1'b0;
    hold_off_req = 1'b0;
    lim_lo       = TEMP_LOW_RST;
    lim_hi       = TEMP_HIGH_RST;
    lines_done   = '0;
    clear_record();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed probes at the reset limits
    foreach (probes[i]) begin
      for (int k = 0; k < probes[i].txt.len(); k++) begin
        b    = probes[i].txt[k];
        last = (k == probes[i].txt.len() - 1) && !probes[i].ends_stream;
        if (b == NUL_MARK) b = 8'h00;
        send_byte(b, 1'b0, probes[i].pin && last, probes[i].mask, probes[i].line);
      end
      if (probes[i].ends_stream)
        send_byte(8'($urandom_range(0, 255)), 1'b1, probes[i].pin, probes[i].mask,
                  probes[i].line);
    end

    // random phases, each under its own pair of limits
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       begin lo = -9999; hi = 9999; end              // widest legal window
        1:       begin lo = 100;   hi = -100; end              // inverted: nothing valid
        2:       begin lo = 0;     hi = 0;    end              // single point
        4:       begin lo = $urandom_range(0, 32767);          // any 15-bit pattern
                       hi = $urandom_range(0, 32767); end
        5:       begin lo = TEMP_LOW_RST; hi = TEMP_HIGH_RST; end
        default: begin lo = -$urandom_range(0, 200); hi = $urandom_range(0, 200); end
      endcase
      program_limits(lo, hi, ph == 0 || ph == NUM_PHASES - 1);

      if (ph == PRESSURE_PHASE) begin
        // receiver holds off while the sender keeps pushing back to back
        hold_off_req = 1'b1;
        src_quiet    = 1'b1;
        sink_quiet   = 1'b0;
        repeat (4) begin
          build_record();
          send_record();
        end
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        src_quiet  = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
        build_record();
        send_record();
        sent += rec_bytes.size() + rec_ends_stream;
      end
      // close any record left open by noise before the limits change
      send_byte(CHAR_NL, 1'b0, 1'b0, '0, '0);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("tb_sensor_record_parser_validator_unit passed");
    end else begin
      $display("tb_sensor_record_parser_validator_unit failed");
    end
    $finish;
  end

endmodule
